// ===== design/nol_pkg.sv =====
// ----------------------------------------------------------------------------
// nol_pkg
// Shared types and constants for the next-occurrence lookup block.
// ----------------------------------------------------------------------------
package nol_pkg;

  localparam int unsigned FuncW       = 2;
  localparam int unsigned SymW        = 8;
  localparam int unsigned CharIdxW    = 3;
  localparam int unsigned PortPosW    = 9;
  localparam int unsigned AlphaW      = 64;
  localparam int unsigned AlphaSizeW  = 4;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 64;
  localparam int unsigned MaxAlphabet = 8;
  localparam int unsigned DefMaxLen   = 256;

  typedef enum logic [FuncW-1:0] {
    FuncClear  = 2'd0,
    FuncAppend = 2'd1,
    FuncQuery  = 2'd2,
    FuncNone   = 2'd3
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAlphaChars = 1'b0,
    CfgAlphaSize  = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    StIdle   = 1'b0,
    StSearch = 1'b1
  } state_e;

  // search token walking down the cell row
  typedef struct packed {
    logic            valid;
    logic            live;
    logic            found;
    logic [SymW-1:0] want;
  } tok_t;

endpackage

// ===== design/nol_cell.sv =====
// ----------------------------------------------------------------------------
// nol_cell
// One string position: holds its symbol and checks the passing search token.
// ----------------------------------------------------------------------------
module nol_cell import nol_pkg::*; #(
  parameter int unsigned CellIdx = 0,
  parameter int unsigned PosW    = 9
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   append_i,
  input  logic [SymW-1:0]        symbol_i,
  input  logic [PosW-1:0]        len_i,
  input  logic [PosW-1:0]        start_i,
  input  tok_t                   tok_i,
  input  logic [PosW-1:0]        pos_i,
  output tok_t                   tok_o,
  output logic [PosW-1:0]        pos_o
);

  // this cell holds string position CellIdx+1
  localparam logic [PosW-1:0] MyPos = PosW'(CellIdx + 1);

  logic [SymW-1:0] sym_q;
  tok_t            tok_d, tok_q;
  logic [PosW-1:0] pos_d, pos_q;
  logic            hit;

  always_ff @(posedge clk_i) begin
    if (append_i && (len_i == PosW'(CellIdx))) begin
      sym_q <= symbol_i;
    end
  end

  assign hit = tok_i.valid && tok_i.live && !tok_i.found &&
               (MyPos > start_i) && (MyPos <= len_i) && (sym_q == tok_i.want);

  always_comb begin
    tok_d = tok_i;
    pos_d = pos_i;
    if (hit) begin
      tok_d.found = 1'b1;
      pos_d       = MyPos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
  end

  assign tok_o = tok_q;
  assign pos_o = pos_q;

endmodule

// ===== design/next_occurrence_lookup.sv =====
// ----------------------------------------------------------------------------
// next_occurrence_lookup
// Stores one byte string and answers next-occurrence queries with a row of
// position cells that a search token walks through.
// ----------------------------------------------------------------------------
// channel   direction  handshake                  payload
// in        request    in_valid_i / in_stall_o    func, symbol, char_index, position
// out       result     out_valid_o / out_stall_i  found, next_position, overflowed
// cfg       write      cfg_we_i                   cfg_index_i, cfg_data_i
//
// clear and append give no result
// a query token steps one cell per cycle down the
// row of MaxLen cells, then the answer is loaded into the output register
// no request is taken while a query token is in the row
// a query waits while an earlier result is still held; clears and appends do not
// reset empties the string and clears the overflow flag; symbols are not cleared
// ----------------------------------------------------------------------------
module next_occurrence_lookup import nol_pkg::*; #(
  parameter int unsigned MaxLen = DefMaxLen
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [FuncW-1:0]      in_func_i,
  input  logic [SymW-1:0]       in_symbol_i,
  input  logic [CharIdxW-1:0]   in_char_index_i,
  input  logic [PortPosW-1:0]   in_position_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  out_found_o,
  output logic [PortPosW-1:0]   out_next_position_o,
  output logic                  out_overflowed_o
);

  localparam int unsigned LenW = $clog2(MaxLen + 1);
  localparam int unsigned PosW = (LenW > PortPosW) ? LenW : PortPosW;

  state_e                state_q, state_d;
  logic [AlphaW-1:0]     alpha_chars_q;
  logic [AlphaSizeW-1:0] alpha_size_q;
  logic [LenW-1:0]       len_q, len_d;
  logic                  ovf_q, ovf_d;
  logic [PosW-1:0]       start_q;
  logic [PosW-1:0]       start_sel;
  logic                  out_valid_q;
  logic                  out_found_q;
  logic [PosW-1:0]       out_pos_q;
  logic                  out_ovf_q;

  logic                  in_acc, out_acc;
  logic                  is_query, is_append, full, do_append;
  logic [AlphaSizeW-1:0] active;
  logic [5:0]            char_sel;
  logic [PosW-1:0]       len_ext;
  tok_t                  tok_chain [MaxLen+1];
  logic [PosW-1:0]       pos_chain [MaxLen+1];
  tok_t                  tail_tok;
  logic [PosW-1:0]       tail_pos;

  assign is_query  = (func_e'(in_func_i) == FuncQuery);
  assign is_append = (func_e'(in_func_i) == FuncAppend);
  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_acc   = out_valid_q && !out_stall_i;
  assign full      = (len_q == LenW'(MaxLen));
  assign do_append = in_acc && is_append && !full;
  assign len_ext   = PosW'(len_q);

  // the first cell checks the token in the cycle the query is taken
  assign start_sel = (in_acc && is_query) ? PosW'(in_position_i) : start_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_chars_q <= '0;
      alpha_size_q  <= AlphaSizeW'(1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgAlphaChars: alpha_chars_q <= cfg_data_i[AlphaW-1:0];
        CfgAlphaSize:  alpha_size_q  <= cfg_data_i[AlphaSizeW-1:0];
        default: ;
      endcase
    end
  end

  // search token injected into the first cell
  assign active   = (alpha_size_q > AlphaSizeW'(MaxAlphabet)) ?
                    AlphaSizeW'(MaxAlphabet) : alpha_size_q;
  assign char_sel = {in_char_index_i, 3'b000};

  always_comb begin
    tok_chain[0].valid = in_acc && is_query;
    tok_chain[0].live  = (AlphaSizeW'(in_char_index_i) < active);
    tok_chain[0].found = 1'b0;
    tok_chain[0].want  = alpha_chars_q[char_sel +: SymW];
    pos_chain[0]       = '0;
  end

  for (genvar i = 0; i < MaxLen; i++) begin : g_cell
    nol_cell #(
      .CellIdx (i),
      .PosW    (PosW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .append_i (do_append),
      .symbol_i (in_symbol_i),
      .len_i    (len_ext),
      .start_i  (start_sel),
      .tok_i    (tok_chain[i]),
      .pos_i    (pos_chain[i]),
      .tok_o    (tok_chain[i+1]),
      .pos_o    (pos_chain[i+1])
    );
  end

  assign tail_tok = tok_chain[MaxLen];
  assign tail_pos = pos_chain[MaxLen];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (in_acc && is_query) state_d = StSearch;
      StSearch: if (tail_tok.valid)     state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // outputs of the controller
  always_comb begin
    case (state_q)
      StIdle:   in_stall_o = is_query && out_valid_q && out_stall_i;
      StSearch: in_stall_o = 1'b1;
      default:  in_stall_o = 1'b1;
    endcase
  end

  // string length and overflow flag
  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    if (in_acc) begin
      case (func_e'(in_func_i))
        FuncClear: begin
          len_d = '0;
          ovf_d = 1'b0;
        end
        FuncAppend: begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            len_d = len_q + LenW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      if (state_q == StSearch && tail_tok.valid) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_query) begin
      start_q <= PosW'(in_position_i);
    end
    if (state_q == StSearch && tail_tok.valid) begin
      out_found_q <= tail_tok.found;
      out_pos_q   <= tail_tok.found ? tail_pos : '0;
      out_ovf_q   <= ovf_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_found_o         = out_found_q;
  assign out_next_position_o = out_pos_q[PortPosW-1:0];
  assign out_overflowed_o    = out_ovf_q;

  // a token only leaves the row while a query is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_tok.valid |-> state_q == StSearch)
    else $error("search token left the row with no query in flight");

  // the result register is free whenever a token reaches the end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_tok.valid |-> !out_valid_q)
    else $error("search finished while an earlier result is held");

  // a hit lies inside the string and after the start position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_tok.valid && tail_tok.found) |->
      (tail_pos > start_q) && (tail_pos <= len_ext))
    else $error("hit position outside the searched range");

  // overflow can only be flagged on a full string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> full)
    else $error("overflow flag set on a string that is not full");

  // the string never changes while a query is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSearch && $past(state_q) == StSearch) |-> $stable(len_q))
    else $error("string length changed during a search");

endmodule
